// ===== sv/fsle_pkg.sv =====
// ----------------------------------------------------------------------------
// fsle_pkg
// Shared types, codes and helpers for the frame segment list engine.
// ----------------------------------------------------------------------------
package fsle_pkg;

  localparam int MAX_SEGMENTS_DEF = 64;

  localparam logic [2:0] MODE_CLEAR   = 3'd0;
  localparam logic [2:0] MODE_APPEND  = 3'd1;
  localparam logic [2:0] MODE_MERGE   = 3'd2;
  localparam logic [2:0] MODE_DELETE  = 3'd3;
  localparam logic [2:0] MODE_LOOKUP  = 3'd4;
  localparam logic [2:0] MODE_REVERSE = 3'd5;
  localparam logic [2:0] MODE_OFFSET  = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_RANGE    = 2'd3;

  localparam logic [30:0] M31 = '1;

  typedef struct packed {
    logic [2:0]         mode;
    logic [30:0]        first_frame;
    logic [30:0]        seg_length;
    logic signed [31:0] shift_amount;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] found_frame;
    logic [30:0] run_length;
    logic [30:0] total_frames;
    logic [6:0]  segment_count;
  } rsp_t;

  typedef struct packed {
    logic [30:0] start;
    logic [30:0] len;
  } seg_t;

  typedef struct packed {
    logic pop;
    logic push;
    seg_t data;
  } fifo_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PASS_A,
    S_PASS_B,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    P_SEARCH,
    P_DEL,
    P_SPLIT,
    P_COPY
  } phase_t;

  function automatic logic [30:0] sat31(input logic [32:0] v);
    sat31 = (v > {2'b00, M31}) ? M31 : v[30:0];
  endfunction

endpackage

// ===== sv/fsle_cell.sv =====
// ----------------------------------------------------------------------------
// fsle_cell
// One table entry; loads new data or takes its right neighbor on a shift.
// ----------------------------------------------------------------------------
module fsle_cell import fsle_pkg::*; (
  input  logic clk,
  input  logic shift,
  input  logic wr,
  input  seg_t din,
  input  seg_t nbr,
  output seg_t q
);

  always_ff @(posedge clk) begin
    if (wr) begin
      q <= din;
    end else if (shift) begin
      q <= nbr;
    end
  end

endmodule

// ===== sv/fsle_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsle_ctrl
// Sequencer and stream processor at the head of the cell chain.
// ----------------------------------------------------------------------------
module fsle_ctrl import fsle_pkg::*; #(
  parameter int MaxSegments = MAX_SEGMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  req_t                               req,
  output logic                               rsp_valid,
  input  logic                               rsp_ready,
  output rsp_t                               rsp,
  input  seg_t                               head,
  output fifo_ctl_t                          ctl,
  output logic [$clog2(MaxSegments+1)-1:0]   cnt
);

  localparam int CntW = $clog2(MaxSegments + 1);
  localparam logic [CntW-1:0] MaxC = CntW'(MaxSegments);

  state_t            state, state_next;
  phase_t            ps, ps_next;
  req_t              rq;
  logic [CntW-1:0]   cnt_next, norig, norig_next, npop, npop_next, sim, sim_next;
  logic [32:0]       wa, wa_next;
  logic [30:0]       wb, wb_next;
  logic [1:0]        st, st_next;
  logic [30:0]       fnd, fnd_next, run, run_next;
  logic [31:0]       sum, sum_next, sum_tmp;
  rsp_t              rsp_next;
  logic              rsp_valid_next;

  logic              have, pass_b, ins;
  logic [30:0]       s, l, off_c, rem_c;
  logic [32:0]       ne, ff33, init_wa;
  logic signed [33:0] v;
  phase_t            init_ps_b;

  assign s       = head.start;
  assign l       = head.len;
  assign ne      = {2'b00, s} + {2'b00, l};
  assign ff33    = {2'b00, rq.first_frame};
  assign v       = $signed({3'b000, s}) + 34'(rq.shift_amount);
  assign have    = (npop != norig);
  assign pass_b  = (state == S_PASS_B);
  assign off_c   = (ps == P_SEARCH) ? wa[30:0] : wb;
  assign rem_c   = (ps == P_SEARCH) ? rq.seg_length : wa[30:0];
  assign sum_tmp = sum + {1'b0, ctl.data.len};

  always_comb begin
    case (rq.mode)
      MODE_MERGE, MODE_APPEND: init_wa = ff33 + {2'b00, rq.seg_length};
      MODE_REVERSE:            init_wa = '0;
      default:                 init_wa = ff33;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      rq <= req;
    end
    ps    <= ps_next;
    norig <= norig_next;
    npop  <= npop_next;
    sim   <= sim_next;
    wa    <= wa_next;
    wb    <= wb_next;
    st    <= st_next;
    fnd   <= fnd_next;
    run   <= run_next;
    sum   <= sum_next;
    rsp   <= rsp_next;
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    norig_next     = norig;
    npop_next      = npop;
    sim_next       = sim;
    ps_next        = ps;
    wa_next        = wa;
    wb_next        = wb;
    st_next        = st;
    fnd_next       = fnd;
    run_next       = run;
    sum_next       = sum;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid;
    ins            = 1'b0;
    init_ps_b      = P_COPY;
    ctl            = '0;
    ctl.data       = head;
    req_ready      = (state == S_IDLE);
    if (rsp_valid && rsp_ready) begin
      rsp_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_LOAD;
        end
      end

      S_LOAD: begin
        norig_next = cnt;
        npop_next  = '0;
        sim_next   = cnt;
        sum_next   = '0;
        fnd_next   = '0;
        run_next   = '0;
        wb_next    = rq.first_frame;
        wa_next    = init_wa;
        st_next    = (rq.mode == MODE_REVERSE) ? ST_NOTFOUND : ST_OK;
        ps_next    = (rq.mode == MODE_APPEND) ? P_COPY : P_SEARCH;
        if (rq.mode == MODE_CLEAR) begin
          cnt_next   = '0;
          state_next = S_DONE;
        end else begin
          state_next = S_PASS_A;
        end
      end

      S_PASS_A, S_PASS_B: begin
        if (have) begin
          if (!pass_b || ps == P_COPY) begin
            ctl.pop  = 1'b1;
            ctl.push = 1'b1;
          end
          if (ps != P_COPY) begin
            case (rq.mode)
              MODE_LOOKUP: begin
                if (wa < {2'b00, l}) begin
                  fnd_next = s + wa[30:0];
                  run_next = l - wa[30:0];
                  ps_next  = P_COPY;
                end else begin
                  wa_next = wa - {2'b00, l};
                end
              end

              MODE_REVERSE: begin
                if (ff33 >= {2'b00, s} && ff33 < ne) begin
                  fnd_next = sat31(wa + (ff33 - {2'b00, s}));
                  st_next  = ST_OK;
                  ps_next  = P_COPY;
                end else if (!wa[32] && !wa[31]) begin
                  wa_next = wa + {2'b00, l};
                end
              end

              MODE_OFFSET: begin
                if (!pass_b) begin
                  if (v[33] || v[32] || v[31]) begin
                    st_next = ST_RANGE;
                    ps_next = P_COPY;
                  end
                end else begin
                  ctl.pop        = 1'b1;
                  ctl.push       = 1'b1;
                  ctl.data.start = v[30:0];
                end
              end

              MODE_MERGE: begin
                if (wa < {2'b00, s}) begin
                  ps_next = P_COPY;
                  if (!pass_b) begin
                    if (sim >= MaxC) begin
                      st_next = ST_FULL;
                    end
                  end else begin
                    ctl.push       = 1'b1;
                    ctl.data.start = wb;
                    ctl.data.len   = sat31(wa - {2'b00, wb});
                  end
                end else if ({2'b00, wb} <= ne) begin
                  if (wa > ne) begin
                    if (s < wb) begin
                      wb_next = s;
                    end
                    sim_next = sim - 1'b1;
                    if (pass_b) begin
                      ctl.pop = 1'b1;
                    end
                  end else begin
                    ps_next = P_COPY;
                    if (pass_b) begin
                      ctl.pop  = 1'b1;
                      ctl.push = 1'b1;
                      if (s > wb) begin
                        ctl.data.start = wb;
                        ctl.data.len   = sat31(ne - {2'b00, wb});
                      end
                    end
                  end
                end else if (pass_b) begin
                  ctl.pop  = 1'b1;
                  ctl.push = 1'b1;
                end
              end

              MODE_DELETE: begin
                if (ps == P_SPLIT) begin
                  ctl.pop        = 1'b1;
                  ctl.push       = 1'b1;
                  ctl.data.start = s + wb + wa[30:0];
                  ctl.data.len   = l - wb - wa[30:0];
                  ps_next        = P_COPY;
                end else if (ps == P_SEARCH && !(wa < {2'b00, l})) begin
                  wa_next = wa - {2'b00, l};
                  if (pass_b) begin
                    ctl.pop  = 1'b1;
                    ctl.push = 1'b1;
                  end
                end else if (rem_c == '0) begin
                  ps_next = P_COPY;
                  if (pass_b) begin
                    ctl.pop  = 1'b1;
                    ctl.push = 1'b1;
                  end
                end else if ((l - off_c) > rem_c) begin
                  if (off_c != '0) begin
                    if (!pass_b) begin
                      if (sim >= MaxC) begin
                        st_next = ST_FULL;
                      end
                      ps_next = P_COPY;
                    end else begin
                      ctl.push     = 1'b1;
                      ctl.data.len = off_c;
                      ps_next      = P_SPLIT;
                      wb_next      = off_c;
                      wa_next      = {2'b00, rem_c};
                    end
                  end else begin
                    ps_next = P_COPY;
                    if (pass_b) begin
                      ctl.pop        = 1'b1;
                      ctl.push       = 1'b1;
                      ctl.data.start = s + rem_c;
                      ctl.data.len   = l - rem_c;
                    end
                  end
                end else begin
                  ps_next = P_DEL;
                  wb_next = '0;
                  wa_next = {2'b00, rem_c - (l - off_c)};
                  if (off_c != '0) begin
                    if (pass_b) begin
                      ctl.pop      = 1'b1;
                      ctl.push     = 1'b1;
                      ctl.data.len = off_c;
                    end
                  end else begin
                    sim_next = sim - 1'b1;
                    if (pass_b) begin
                      ctl.pop = 1'b1;
                    end
                  end
                end
              end

              default: begin
                if (pass_b) begin
                  ctl.pop  = 1'b1;
                  ctl.push = 1'b1;
                end
              end
            endcase
          end
          npop_next = npop + CntW'(ctl.pop);
        end else begin
          ins = (rq.mode == MODE_APPEND && (!pass_b || st == ST_OK)) ||
                (rq.mode == MODE_MERGE && ps == P_SEARCH);
          if (!pass_b) begin
            if (ins && sim >= MaxC) begin
              st_next = ST_FULL;
            end
            if (ps == P_SEARCH && (rq.mode == MODE_LOOKUP || rq.mode == MODE_DELETE)) begin
              st_next = ST_NOTFOUND;
            end
            if (st_next == ST_OK && (rq.mode == MODE_MERGE || rq.mode == MODE_DELETE ||
                                     rq.mode == MODE_OFFSET)) begin
              init_ps_b = P_SEARCH;
            end
            npop_next  = '0;
            sim_next   = cnt;
            sum_next   = '0;
            wb_next    = rq.first_frame;
            wa_next    = init_wa;
            ps_next    = init_ps_b;
            state_next = S_PASS_B;
          end else begin
            if (ins) begin
              ctl.push       = 1'b1;
              ctl.data.start = wb;
              ctl.data.len   = sat31(wa - {2'b00, wb});
            end
            state_next = S_DONE;
          end
        end
        if (pass_b) begin
          if (ctl.push) begin
            sum_next = sum_tmp[31] ? {1'b0, M31} : sum_tmp;
          end
          cnt_next = cnt + CntW'(ctl.push) - CntW'(ctl.pop);
        end
      end

      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.status        = st;
          rsp_next.found_frame   = fnd;
          rsp_next.run_length    = run;
          rsp_next.total_frames  = sum[30:0];
          rsp_next.segment_count = 7'(cnt);
          rsp_valid_next         = 1'b1;
          state_next             = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= MaxC)
    else $error("segment count above table size");
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && !ctl.pop && cnt == MaxC))
    else $error("insert into full table");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(ctl.pop && cnt == '0))
    else $error("pop from empty table");
  a_check_pass_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS_A) |=> (cnt == $past(cnt)))
    else $error("check pass changed the table");
`endif

endmodule

// ===== sv/frame_segment_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// frame_segment_list_engine_unit
// Ordered segment table held in a chain of cells, with list operations.
// ----------------------------------------------------------------------------
// The table is a chain of cells read only at its head, and a request walks it
// twice, one entry per cycle, first to check and find, then to rewrite; a merge
// insert that lands ahead of a held segment or a delete that splits a segment
// adds an insert step to the rewrite walk, and clear walks nothing. A new
// request is taken once the walks end and the response is registered, even
// while that response still waits.
module frame_segment_list_engine_unit import fsle_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CntW = $clog2(MAX_SEGMENTS + 1);

  fifo_ctl_t       ctl;
  logic [CntW-1:0] cnt, wi;
  seg_t            q [MAX_SEGMENTS];

  assign wi = ctl.pop ? cnt - 1'b1 : cnt;

  fsle_ctrl #(.MaxSegments(MAX_SEGMENTS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .head      (q[0]),
    .ctl       (ctl),
    .cnt       (cnt)
  );

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    seg_t nbr;
    if (k == MAX_SEGMENTS - 1) begin : g_last
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = q[k+1];
    end
    fsle_cell u_cell (
      .clk   (clk),
      .shift (ctl.pop),
      .wr    (ctl.push && (wi == CntW'(k))),
      .din   (ctl.data),
      .nbr   (nbr),
      .q     (q[k])
    );
  end

endmodule

// ===== test/fsle_checker.sv =====
// ----------------------------------------------------------------------------
// fsle_checker
// Watches the request and response channels of the frame segment list engine,
// keeps its own copy of the segment table and compares every response.
// ----------------------------------------------------------------------------
module fsle_checker import fsle_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEG = MAX_SEGMENTS_DEF;

  logic [30:0] tbl_start [NSEG+1];
  logic [30:0] tbl_len [NSEG+1];
  int tbl_used;
  rsp_t rsp_queue[$];

  function automatic logic [30:0] clamp31(longint v);
    return (v > longint'(M31)) ? M31 : v[30:0];
  endfunction

  function automatic void drop_seg(int i);
    for (int k = i; k + 1 < tbl_used; k++) begin
      tbl_start[k] = tbl_start[k+1];
      tbl_len[k] = tbl_len[k+1];
    end
    tbl_used--;
  endfunction

  function automatic void put_seg(int i, longint s, longint l);
    for (int k = tbl_used; k > i; k--) begin
      tbl_start[k] = tbl_start[k-1];
      tbl_len[k] = tbl_len[k-1];
    end
    tbl_start[i] = s[30:0];
    tbl_len[i] = l[30:0];
    tbl_used++;
  endfunction

  function automatic int locate_out(longint f, output longint off);
    for (int i = 0; i < tbl_used; i++) begin
      if (f < longint'(tbl_len[i])) begin
        off = f;
        return i;
      end
      f -= tbl_len[i];
    end
    off = 0;
    return tbl_used;
  endfunction

  function automatic logic [1:0] merge_seg(longint st, longint ln);
    int i;
    longint ns, ne, e;
    i = 0;
    while (i < tbl_used) begin
      ns = tbl_start[i];
      ne = ns + tbl_len[i];
      e = st + ln;
      if (e < ns) begin
        if (tbl_used >= NSEG) return ST_FULL;
        put_seg(i, st, clamp31(ln));
        return ST_OK;
      end
      if (st <= ne) begin
        if (e > ne) begin
          if (ns < st) begin
            ln = e - ns;
            st = ns;
          end
          drop_seg(i);
          continue;
        end
        if (ns > st) begin
          tbl_len[i] = clamp31(ne - st);
          tbl_start[i] = st[30:0];
        end
        return ST_OK;
      end
      i++;
    end
    if (tbl_used >= NSEG) return ST_FULL;
    put_seg(tbl_used, st, clamp31(ln));
    return ST_OK;
  endfunction

  function automatic logic [1:0] cut_range(longint st, longint ln);
    longint off, l;
    int i;
    i = locate_out(st, off);
    if (i >= tbl_used) return ST_NOTFOUND;
    while (i < tbl_used && ln > 0) begin
      l = tbl_len[i];
      if (l - off > ln) begin
        if (off != 0) begin
          if (tbl_used >= NSEG) return ST_FULL;
          put_seg(i + 1, longint'(tbl_start[i]) + off + ln, l - (off + ln));
          tbl_len[i] = off[30:0];
        end else begin
          tbl_start[i] = tbl_start[i] + ln[30:0];
          tbl_len[i] = l[30:0] - ln[30:0];
        end
        break;
      end
      if (off != 0) begin
        ln -= l - off;
        tbl_len[i] = off[30:0];
        i++;
      end else begin
        ln -= l;
        drop_seg(i);
      end
      off = 0;
    end
    return ST_OK;
  endfunction

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    longint off, acc, s, v, tot;
    int i;
    o = '0;
    case (r.mode)
      MODE_CLEAR: tbl_used = 0;
      MODE_APPEND: begin
        if (tbl_used >= NSEG) o.status = ST_FULL;
        else put_seg(tbl_used, r.first_frame, r.seg_length);
      end
      MODE_MERGE: o.status = merge_seg(r.first_frame, r.seg_length);
      MODE_DELETE: o.status = cut_range(r.first_frame, r.seg_length);
      MODE_LOOKUP: begin
        i = locate_out(r.first_frame, off);
        if (i >= tbl_used) o.status = ST_NOTFOUND;
        else begin
          o.found_frame = tbl_start[i] + off[30:0];
          o.run_length = tbl_len[i] - off[30:0];
        end
      end
      MODE_REVERSE: begin
        acc = 0;
        o.status = ST_NOTFOUND;
        for (i = 0; i < tbl_used; i++) begin
          s = tbl_start[i];
          if (r.first_frame >= s && r.first_frame < s + tbl_len[i]) begin
            o.found_frame = clamp31(acc + (r.first_frame - s));
            o.status = ST_OK;
            break;
          end
          acc += tbl_len[i];
        end
      end
      MODE_OFFSET: begin
        for (i = 0; i < tbl_used; i++) begin
          v = longint'(tbl_start[i]) + longint'(r.shift_amount);
          if (v < 0 || v > longint'(M31)) begin
            o.status = ST_RANGE;
            break;
          end
        end
        if (o.status == ST_OK)
          for (i = 0; i < tbl_used; i++)
            tbl_start[i] = tbl_start[i] + r.shift_amount[30:0];
      end
      default: ;
    endcase
    tot = 0;
    for (i = 0; i < tbl_used; i++) tot += tbl_len[i];
    o.total_frames = clamp31(tot);
    o.segment_count = tbl_used[6:0];
    return o;
  endfunction

  assign pending = rsp_queue.size();

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      tbl_used = 0;
      rsp_queue.delete();
      errors = 0;
    end else begin
      if (req_valid && req_ready) rsp_queue.push_back(apply_request(req));
      if (rsp_valid && rsp_ready) begin
        if (rsp_queue.size() == 0) begin
          $error("response with nothing expected");
          errors++;
        end else begin
          want = rsp_queue.pop_front();
          if (rsp.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.found_frame !== want.found_frame) begin
            $error("found_frame exp %0d got %0d", want.found_frame, rsp.found_frame);
            errors++;
          end
          if (rsp.run_length !== want.run_length) begin
            $error("run_length exp %0d got %0d", want.run_length, rsp.run_length);
            errors++;
          end
          if (rsp.total_frames !== want.total_frames) begin
            $error("total_frames exp %0d got %0d", want.total_frames, rsp.total_frames);
            errors++;
          end
          if (rsp.segment_count !== want.segment_count) begin
            $error("segment_count exp %0d got %0d", want.segment_count,
                   rsp.segment_count);
            errors++;
          end
        end
      end
    end
  end
endmodule

// ===== test/tb_frame_segment_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// tb_frame_segment_list_engine_unit
// Drives directed and random segment list requests with bursty input and a
// stalling output; the checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_frame_segment_list_engine_unit;
  import fsle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic req_valid = 0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 0;
  rsp_t rsp;
  int errors;
  int pending;
  int sent = 0;
  bit hold_off = 0;
  bit stalled_once = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  frame_segment_list_engine_unit DUT (.*);

  fsle_checker u_checker (.*);

  function automatic logic [30:0] pick31();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return M31;
      2: return 31'($urandom_range(0, 40));
      3: return 31'($urandom_range(0, 400));
      4: return M31 - 31'($urandom_range(0, 40));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic send_request(logic [2:0] m, logic [30:0] ff, logic [30:0] sl,
                              logic [31:0] sh);
    req_valid <= 1;
    req <= '{mode: m, first_frame: ff, seg_length: sl, shift_amount: sh};
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sent++;
  endtask

  task automatic gap();
    int g;
    g = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (g > 0) begin
      req_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic random_request();
    logic [2:0] m;
    logic [31:0] sh;
    int k;
    k = $urandom_range(0, 99);
    if (k < 25) m = MODE_APPEND;
    else if (k < 45) m = MODE_MERGE;
    else if (k < 58) m = MODE_DELETE;
    else if (k < 72) m = MODE_LOOKUP;
    else if (k < 84) m = MODE_REVERSE;
    else if (k < 95) m = MODE_OFFSET;
    else if (k < 98) m = MODE_CLEAR;
    else m = 3'd7;
    case ($urandom_range(0, 3))
      0: sh = $urandom;
      1: sh = 32'($signed($urandom_range(0, 200)) - 100);
      2: sh = 32'h8000_0000;
      default: sh = 32'h7FFF_FFFF;
    endcase
    send_request(m, pick31(), pick31(), sh);
  endtask

  initial begin
    int burst;
    repeat (2) @(posedge clk);
    rst <= 0;
    // directed
    send_request(MODE_LOOKUP, 0, 0, 0);
    send_request(MODE_DELETE, 0, 5, 0);
    send_request(MODE_APPEND, 100, 10, 0);
    send_request(MODE_APPEND, M31 - 5, M31, 0);
    send_request(MODE_LOOKUP, 12, 0, 0);
    send_request(MODE_REVERSE, M31 - 2, 0, 0);
    send_request(MODE_REVERSE, 5, 0, 0);
    send_request(MODE_CLEAR, 0, 0, 0);
    send_request(MODE_MERGE, 100, 10, 0);
    send_request(MODE_MERGE, 110, 5, 0);
    send_request(MODE_MERGE, 95, 7, 0);
    send_request(MODE_MERGE, 200, 3, 0);
    send_request(MODE_MERGE, 90, 200, 0);
    send_request(MODE_MERGE, 5, M31, 0);
    send_request(MODE_CLEAR, 0, 0, 0);
    send_request(MODE_APPEND, 50, 20, 0);
    send_request(MODE_DELETE, 5, 3, 0);
    send_request(MODE_DELETE, 0, 0, 0);
    send_request(MODE_DELETE, 500, 1, 0);
    send_request(MODE_OFFSET, 0, 0, 32'hFFFF_FF00);
    send_request(MODE_OFFSET, 0, 0, 32'sd1000);
    send_request(MODE_OFFSET, 0, 0, 32'h7FFF_FFFF);
    send_request(3'd7, M31, M31, 32'hFFFF_FFFF);
    for (int i = 0; i < 66; i++) send_request(MODE_APPEND, 10 * i, 3, 0);
    send_request(MODE_MERGE, 2000, 1, 0);
    send_request(MODE_DELETE, 1, 1, 0);
    // random, with a long receiver hold-off in the middle
    while (sent < 1500) begin
      if (sent > 600 && !stalled_once) begin
        hold_off = 1;
        stalled_once = 1;
      end
      burst = $urandom_range(1, 30);
      repeat (burst) random_request();
      if ($urandom_range(0, 40) == 0) send_request(MODE_CLEAR, 0, 0, 0);
      gap();
      if (sent > 1000 && sent < 1040) begin
        req_valid <= 0;
        while (pending != 0) @(posedge clk);
      end
    end
    req_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d requests over all modes, full table, splits and range errors",
             sent);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      stall = $urandom_range(0, 15);
      rsp_ready <= (stall > 4) || (stall == 0 && $urandom_range(0, 1) == 1);
    end
  end

  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/fsle_pkg.sv
sv/fsle_cell.sv
sv/fsle_ctrl.sv
sv/frame_segment_list_engine_unit.sv
test/fsle_checker.sv
test/tb_frame_segment_list_engine_unit.sv
